### src/mouse_event_classifier_macros.svh
// Assertion macros used by the checker file of the mouse event classifier.
`ifndef MOUSE_EVENT_CLASSIFIER_MACROS_SVH
`define MOUSE_EVENT_CLASSIFIER_MACROS_SVH

// Property checked on each rising clock edge, ignored while reset is asserted.
`define MEC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked on each rising clock edge, reset included.
`define MEC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### src/mec_pkg.sv
package mec_pkg;

  // Field widths of one poll and one result.
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned EV_W    = 5;
  localparam int unsigned DLY_W   = 16;

  // Stream and configuration port widths.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_MOUSE_ENABLE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_HAND     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_ROWS   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_COLS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DCLICK_TICKS  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RPT_START     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RPT_TICKS     = 3'd6;

  // Button codes.
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;
  localparam logic [1:0] BTN_NONE   = 2'd3;

  // Event kinds, added to the base code of the tagged button.
  localparam logic [2:0] KIND_PRESS   = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_DCLICK  = 3'd2;
  localparam logic [2:0] KIND_DRAG    = 3'd3;
  localparam logic [2:0] KIND_REPEAT  = 3'd4;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE       = 5'd0;
  localparam logic [EV_W-1:0] EV_MOVE       = 5'd1;
  localparam logic [EV_W-1:0] EV_BASE_LEFT  = 5'd2;
  localparam logic [EV_W-1:0] EV_BASE_RIGHT = 5'd7;
  localparam logic [EV_W-1:0] EV_BASE_MID   = 5'd12;
  localparam logic [EV_W-1:0] EV_MAX        = 5'd16;

  // One poll as held in the input register.
  typedef struct packed {
    logic [TICK_W-1:0]       tick_now;
    logic signed [RAW_W-1:0] raw_col;
    logic signed [RAW_W-1:0] raw_row;
    logic [BTN_W-1:0]        button_bits;
  } poll_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [POS_W-1:0] clamped_col;
    logic [POS_W-1:0] clamped_row;
    logic [EV_W-1:0]  event_code;
  } result_t;

  // Single left or right bit selects that button, anything else the middle one.
  function automatic logic [1:0] pick_button(input logic [BTN_W-1:0] bits);
    logic [1:0] b;
    b = BTN_MIDDLE;
    if (bits == 3'b001) b = BTN_LEFT;
    else if (bits == 3'b010) b = BTN_RIGHT;
    return b;
  endfunction

  // Event code for a kind and a button, with left and right swapped in left-hand mode.
  function automatic logic [EV_W-1:0] tag_event(input logic [2:0] kind,
                                                 input logic [1:0] button,
                                                 input logic       left_hand);
    logic [EV_W-1:0] base;
    base = EV_BASE_MID;
    if (button == BTN_LEFT) base = left_hand ? EV_BASE_RIGHT : EV_BASE_LEFT;
    else if (button == BTN_RIGHT) base = left_hand ? EV_BASE_LEFT : EV_BASE_RIGHT;
    return base + {2'b00, kind};
  endfunction

endpackage

### src/mouse_event_classifier.sv
// Mouse event classifier: takes one mouse poll per item on the slave stream (buttons,
// raw row and column, tick count), clamps the position to the configured screen and
// emits one result item per poll with an event code (none, move, or press, release,
// double click, drag or auto-repeat tagged left, right or middle) and the clamped
// position. A poll can be accepted every cycle while the output is not stalled; each
// poll is held in the input register and goes through one classification step into
// the result register, which is also where the stored mouse state is updated. Output
// back-pressure stalls the input once both registers are full. Configuration registers
// are written through the plain write port; the user must write them only while no
// poll is in flight, as the block itself does not enforce this.
module mouse_event_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Poll stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: button_bits[2:0], raw_row[18:3], raw_col[34:19],
  // tick_now[66:35], zero fill[71:67].
  input  logic [mec_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: event_code[4:0], clamped_row[12:5], clamped_col[20:13],
  // zero fill[23:21].
  output logic [mec_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [mec_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [mec_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import mec_pkg::*;

  // Configuration registers.
  logic               enable_q;
  logic               left_hand_q;
  logic [POS_W-1:0]   screen_rows_q;
  logic [POS_W-1:0]   screen_cols_q;
  logic [DLY_W-1:0]   dclick_ticks_q;
  logic [DLY_W-1:0]   rpt_start_q;
  logic [DLY_W-1:0]   rpt_ticks_q;

  // Handshake and pipeline registers.
  logic    in_valid_q;
  poll_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t out_d;
  logic    s_accept;
  logic    out_ready;
  logic    advance;

  // Stored mouse state.
  logic [POS_W-1:0]  prev_row_q, prev_row_d;
  logic [POS_W-1:0]  prev_col_q, prev_col_d;
  logic [BTN_W-1:0]  prev_btn_q, prev_btn_d;
  logic [1:0]        last_btn_q, last_btn_d;
  logic [TICK_W-1:0] mark_q, mark_d;
  logic              repeating_q, repeating_d;

  // Classification signals.
  logic [POS_W-1:0]  row_c;
  logic [POS_W-1:0]  col_c;
  logic [BTN_W-1:0]  diff;
  logic [TICK_W-1:0] elapsed;
  logic              moved;
  logic [1:0]        diff_btn;
  logic [1:0]        held_btn;
  logic [EV_W-1:0]   ev;

  // Clamp a signed coordinate to [0, size-1]; a size of zero clamps to zero.
  function automatic logic [POS_W-1:0] clamp_coord(input logic signed [RAW_W-1:0] raw,
                                                   input logic [POS_W-1:0]        size);
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] res;
    top = (size == '0) ? '0 : size - 1'b1;
    if (raw[RAW_W-1]) begin
      res = '0;
    end else if ((raw[RAW_W-2:POS_W] != '0) || (raw[POS_W-1:0] > top)) begin
      res = top;
    end else begin
      res = raw[POS_W-1:0];
    end
    return res;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b1;
      left_hand_q    <= 1'b0;
      screen_rows_q  <= 8'd25;
      screen_cols_q  <= 8'd80;
      dclick_ticks_q <= 16'd6;
      rpt_start_q    <= 16'd10;
      rpt_ticks_q    <= 16'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MOUSE_ENABLE: enable_q       <= cfg_wdata_i[0];
        REG_LEFT_HAND:    left_hand_q    <= cfg_wdata_i[0];
        REG_SCREEN_ROWS:  screen_rows_q  <= cfg_wdata_i[POS_W-1:0];
        REG_SCREEN_COLS:  screen_cols_q  <= cfg_wdata_i[POS_W-1:0];
        REG_DCLICK_TICKS: dclick_ticks_q <= cfg_wdata_i;
        REG_RPT_START:    rpt_start_q    <= cfg_wdata_i;
        REG_RPT_TICKS:    rpt_ticks_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshakes: the input register moves on whenever the result register is free.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= poll_t'(s_axis_tdata[BTN_W+2*RAW_W+TICK_W-1:0]);
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Classify the poll held in the input register against the stored state.
  assign row_c    = clamp_coord(in_q.raw_row, screen_rows_q);
  assign col_c    = clamp_coord(in_q.raw_col, screen_cols_q);
  assign diff     = in_q.button_bits ^ prev_btn_q;
  assign elapsed  = in_q.tick_now - mark_q;
  assign moved    = (row_c != prev_row_q) || (col_c != prev_col_q);
  assign diff_btn = pick_button(diff);
  assign held_btn = pick_button(in_q.button_bits);

  always_comb begin
    ev          = EV_NONE;
    prev_row_d  = prev_row_q;
    prev_col_d  = prev_col_q;
    prev_btn_d  = prev_btn_q;
    last_btn_d  = last_btn_q;
    mark_d      = mark_q;
    repeating_d = repeating_q;
    if (enable_q) begin
      priority if (moved) begin
        // Movement: drag while any button was held, else a plain move.
        last_btn_d = BTN_NONE;
        ev = (prev_btn_q != '0) ? tag_event(KIND_DRAG, held_btn, left_hand_q) : EV_MOVE;
      end else if (diff != '0) begin
        // Button change in place: press, double click or release.
        if ((diff & in_q.button_bits) == diff) begin
          if ((diff_btn == last_btn_q) &&
              (elapsed < {{(TICK_W-DLY_W){1'b0}}, dclick_ticks_q})) begin
            ev = tag_event(KIND_DCLICK, diff_btn, left_hand_q);
          end else begin
            ev = tag_event(KIND_PRESS, diff_btn, left_hand_q);
            last_btn_d = diff_btn;
          end
        end else begin
          ev = tag_event(KIND_RELEASE, diff_btn, left_hand_q);
        end
        prev_btn_d  = in_q.button_bits;
        repeating_d = 1'b0;
        mark_d      = in_q.tick_now;
      end else if (in_q.button_bits != '0) begin
        // Held without change: auto-repeat after the start delay, then the repeat delay.
        if (!repeating_q) begin
          if (elapsed > {{(TICK_W-DLY_W){1'b0}}, rpt_start_q}) begin
            ev = tag_event(KIND_REPEAT, held_btn, left_hand_q);
            repeating_d = 1'b1;
            mark_d = in_q.tick_now;
          end
        end else if (elapsed > {{(TICK_W-DLY_W){1'b0}}, rpt_ticks_q}) begin
          ev = tag_event(KIND_REPEAT, held_btn, left_hand_q);
          mark_d = in_q.tick_now;
        end
      end else begin
        ev = EV_NONE;
      end
      prev_row_d = row_c;
      prev_col_d = col_c;
    end
    out_d.event_code  = ev;
    out_d.clamped_row = row_c;
    out_d.clamped_col = col_c;
  end

  // State is committed as the poll moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q  <= '0;
      prev_col_q  <= '0;
      prev_btn_q  <= '0;
      last_btn_q  <= BTN_NONE;
      mark_q      <= '0;
      repeating_q <= 1'b0;
    end else if (advance) begin
      prev_row_q  <= prev_row_d;
      prev_col_q  <= prev_col_d;
      prev_btn_q  <= prev_btn_d;
      last_btn_q  <= last_btn_d;
      mark_q      <= mark_d;
      repeating_q <= repeating_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-EV_W-2*POS_W){1'b0}}, out_q};

endmodule

### src/mec_checker.sv
`include "mouse_event_classifier_macros.svh"

// Port-level checks of the mouse event classifier.
module mec_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mec_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mec_pkg::*;

  // A stalled result item keeps its contents.
  `MEC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // Every accepted poll is followed by a valid result item on the result stream.
  `MEC_ASSERT(a_accept_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)

  // Event codes stay within the defined range.
  `MEC_ASSERT(a_event_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[EV_W-1:0] <= EV_MAX)

  // No result item is offered while reset is held.
  `MEC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind mouse_event_classifier mec_checker u_mec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
